FILE: design/trie_longest_prefix_match_defines.svh
// Assertion macros for the route table block.
// TLPM_ASSERT_IMPL checks ante |-> cons, TLPM_ASSERT_NEXT checks ante |=> cons.
`ifndef TRIE_LONGEST_PREFIX_MATCH_DEFINES_SVH
`define TRIE_LONGEST_PREFIX_MATCH_DEFINES_SVH

`ifndef SYNTHESIS
`define TLPM_ASSERT_IMPL(name_, clk_, rstn_, ante_, cons_) \
  name_: assert property (@(posedge clk_) disable iff (!rstn_) (ante_) |-> (cons_)) \
    else $error("tlpm assertion failed");
`define TLPM_ASSERT_NEXT(name_, clk_, rstn_, ante_, cons_) \
  name_: assert property (@(posedge clk_) disable iff (!rstn_) (ante_) |=> (cons_)) \
    else $error("tlpm assertion failed");
`else
`define TLPM_ASSERT_IMPL(name_, clk_, rstn_, ante_, cons_)
`define TLPM_ASSERT_NEXT(name_, clk_, rstn_, ante_, cons_)
`endif

`endif

FILE: design/tlpm_pkg.sv
`timescale 1ns / 1ps

package tlpm_pkg;

  // Default node store depth
  localparam int NODES_DEF = 4096;

  // Field widths
  localparam int KEY_W  = 32;
  localparam int HOP_W  = 32;
  localparam int PORT_W = 8;
  localparam int LEN_W  = 6;
  localparam int STAT_W = 2;

  // Deepest trie level (one level per address bit)
  localparam logic [LEN_W-1:0] DEPTH_MAX = 6'd32;

  // Operation codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_FIN  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;    // latch a new word
    logic step;    // walk one trie level
    logic finish;  // store route or fetch matched route
    logic emit;    // load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic walk_end;  // current level is the last one
    logic out_free;  // result register can take a word
  } sts_t;

endpackage

FILE: design/tlpm_ctrl.sv
`timescale 1ns / 1ps
`include "trie_longest_prefix_match_defines.svh"

module tlpm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tlpm_pkg::sts_t   sts_i,
  output tlpm_pkg::cmd_t   cmd_o
);

  tlpm_pkg::state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      tlpm_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = tlpm_pkg::S_WALK;
        end
      end
      tlpm_pkg::S_WALK: begin
        cmd_o.step = 1'b1;
        if (sts_i.walk_end) begin
          state_d = tlpm_pkg::S_FIN;
        end
      end
      tlpm_pkg::S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = tlpm_pkg::S_OUT;
      end
      tlpm_pkg::S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = tlpm_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = tlpm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tlpm_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `TLPM_ASSERT_IMPL(a_emit_free, clk_i, rst_ni, cmd_o.emit, sts_i.out_free)

endmodule

FILE: design/tlpm_dp.sv
`timescale 1ns / 1ps
`include "trie_longest_prefix_match_defines.svh"

module tlpm_dp #(
  parameter int NODES = tlpm_pkg::NODES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tlpm_pkg::cmd_t                cmd_i,
  output tlpm_pkg::sts_t                sts_o,
  // input word fields
  input  logic                          func_i,
  input  logic [tlpm_pkg::KEY_W-1:0]    key_addr_i,
  input  logic [tlpm_pkg::KEY_W-1:0]    mask_i,
  input  logic [tlpm_pkg::HOP_W-1:0]    hop_addr_i,
  input  logic [tlpm_pkg::PORT_W-1:0]   port_i,
  // result register
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tlpm_pkg::STAT_W-1:0]   status_o,
  output logic [tlpm_pkg::HOP_W-1:0]    hop_out_o,
  output logic [tlpm_pkg::PORT_W-1:0]   port_out_o,
  output logic [tlpm_pkg::LEN_W-1:0]    match_len_o
);

  localparam int IDXW = $clog2(NODES);
  localparam int UW   = $clog2(NODES + 1);
  // node word: {left, right, valid}
  localparam int WW   = 2 * IDXW + 1;
  // route word: {hop, port, len}
  localparam int RW   = tlpm_pkg::HOP_W + tlpm_pkg::PORT_W + tlpm_pkg::LEN_W;

  // Latched word and walk state
  logic                        func_q;
  logic [tlpm_pkg::KEY_W-1:0]  key_q;
  logic [tlpm_pkg::KEY_W-1:0]  mask_q;
  logic [tlpm_pkg::HOP_W-1:0]  hop_q;
  logic [tlpm_pkg::PORT_W-1:0] port_q;
  logic [IDXW-1:0]             p_q;
  logic                        fresh_q;
  logic [tlpm_pkg::LEN_W-1:0]  depth_q;
  logic                        full_q;
  logic                        found_q;
  logic [IDXW-1:0]             best_q;
  logic [UW-1:0]               nodes_used_q;

  // Root node lives in flops so reset clears it at once
  logic [IDXW-1:0]             root_left_q;
  logic [IDXW-1:0]             root_right_q;
  logic                        root_valid_q;

  // Node and route stores
  logic [WW-1:0]               node_mem [NODES];
  logic [WW-1:0]               node_rd_q;
  logic [RW-1:0]               route_mem [NODES];
  logic [RW-1:0]               route_rd_q;

  // Result register
  logic                        out_valid_q;
  logic [tlpm_pkg::STAT_W-1:0] out_status_q;
  logic [tlpm_pkg::HOP_W-1:0]  out_hop_q;
  logic [tlpm_pkg::PORT_W-1:0] out_port_q;
  logic [tlpm_pkg::LEN_W-1:0]  out_len_q;

  // Current node word: root flops, a fresh (empty) node, or the last read
  logic [IDXW-1:0] cur_left, cur_right, child, new_idx;
  logic            cur_valid, at_root, is_lookup, pool_full, want;
  logic            descend, alloc, hit_full;

  always_comb begin
    at_root = (p_q == '0);
    if (at_root) begin
      cur_left  = root_left_q;
      cur_right = root_right_q;
      cur_valid = root_valid_q;
    end else if (fresh_q) begin
      cur_left  = '0;
      cur_right = '0;
      cur_valid = 1'b0;
    end else begin
      cur_left  = node_rd_q[WW-1 -: IDXW];
      cur_right = node_rd_q[IDXW:1];
      cur_valid = node_rd_q[0];
    end
  end

  // Level decision: descend to a child, allocate one, or stop
  always_comb begin
    is_lookup = (func_q == tlpm_pkg::FUNC_LOOKUP);
    child     = key_q[tlpm_pkg::KEY_W-1] ? cur_right : cur_left;
    pool_full = (nodes_used_q == UW'(NODES));
    new_idx   = nodes_used_q[IDXW-1:0];
    // insert goes on while the mask still has leading ones
    want      = (depth_q < tlpm_pkg::DEPTH_MAX) &&
                (is_lookup || mask_q[tlpm_pkg::KEY_W-1]);
    descend   = want && (child != '0);
    alloc     = !is_lookup && want && (child == '0) && !pool_full;
    hit_full  = !is_lookup && want && (child == '0) && pool_full;
    sts_o.walk_end = !(descend || alloc);
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  // Node store write port: parent link on allocation, final word on insert
  logic            nw_en;
  logic [IDXW-1:0] nw_addr;
  logic [WW-1:0]   nw_data;
  logic            ins_fin;

  always_comb begin
    ins_fin = cmd_i.finish && !is_lookup;
    nw_en   = 1'b0;
    nw_addr = p_q;
    nw_data = {cur_left, cur_right, cur_valid};
    if (cmd_i.step && alloc) begin
      nw_en = !at_root;
      if (key_q[tlpm_pkg::KEY_W-1]) begin
        nw_data = {cur_left, new_idx, cur_valid};
      end else begin
        nw_data = {new_idx, cur_right, cur_valid};
      end
    end else if (ins_fin) begin
      nw_en   = !at_root;
      nw_data = {cur_left, cur_right, cur_valid | !full_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (nw_en) begin
      node_mem[nw_addr] <= nw_data;
    end
    if (cmd_i.step && descend) begin
      node_rd_q <= node_mem[child];
    end
  end

  // Route store: written at the end of a good insert, read for a lookup hit
  always_ff @(posedge clk_i) begin
    if (ins_fin && !full_q) begin
      route_mem[p_q] <= {hop_q, port_q, depth_q};
    end
    if (cmd_i.finish && is_lookup && found_q) begin
      route_rd_q <= route_mem[best_q];
    end
  end

  // Walk control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q          <= '0;
      fresh_q      <= 1'b0;
      depth_q      <= '0;
      full_q       <= 1'b0;
      found_q      <= 1'b0;
      best_q       <= '0;
      nodes_used_q <= UW'(1);
      root_left_q  <= '0;
      root_right_q <= '0;
      root_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        p_q     <= '0;
        fresh_q <= 1'b0;
        depth_q <= '0;
        full_q  <= 1'b0;
        found_q <= 1'b0;
        best_q  <= '0;
      end
      if (cmd_i.step) begin
        if (is_lookup && cur_valid) begin
          found_q <= 1'b1;
          best_q  <= p_q;
        end
        if (descend) begin
          p_q     <= child;
          fresh_q <= 1'b0;
          depth_q <= depth_q + 6'd1;
        end
        if (alloc) begin
          p_q          <= new_idx;
          fresh_q      <= 1'b1;
          depth_q      <= depth_q + 6'd1;
          nodes_used_q <= nodes_used_q + UW'(1);
          if (at_root && key_q[tlpm_pkg::KEY_W-1]) begin
            root_right_q <= new_idx;
          end
          if (at_root && !key_q[tlpm_pkg::KEY_W-1]) begin
            root_left_q <= new_idx;
          end
        end
        if (hit_full) begin
          full_q <= 1'b1;
        end
      end
      if (ins_fin && at_root && !full_q) begin
        root_valid_q <= 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Word payload: key and mask shift one bit per level
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      key_q  <= key_addr_i;
      mask_q <= mask_i;
      hop_q  <= hop_addr_i;
      port_q <= port_i;
    end else if (cmd_i.step && (descend || alloc)) begin
      key_q  <= {key_q[tlpm_pkg::KEY_W-2:0], 1'b0};
      mask_q <= {mask_q[tlpm_pkg::KEY_W-2:0], 1'b0};
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_hop_q  <= '0;
      out_port_q <= '0;
      out_len_q  <= '0;
      if (!is_lookup) begin
        out_status_q <= full_q ? tlpm_pkg::ST_FULL : tlpm_pkg::ST_OK;
      end else if (found_q) begin
        out_status_q <= tlpm_pkg::ST_OK;
        out_hop_q    <= route_rd_q[RW-1 -: tlpm_pkg::HOP_W];
        out_port_q   <= route_rd_q[tlpm_pkg::LEN_W +: tlpm_pkg::PORT_W];
        out_len_q    <= route_rd_q[tlpm_pkg::LEN_W-1:0];
      end else begin
        out_status_q <= tlpm_pkg::ST_MISS;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign hop_out_o   = out_hop_q;
  assign port_out_o  = out_port_q;
  assign match_len_o = out_len_q;

  `TLPM_ASSERT_IMPL(a_used_range, clk_i, rst_ni, 1'b1,
    (nodes_used_q != '0) && (nodes_used_q <= UW'(NODES)))
  `TLPM_ASSERT_IMPL(a_depth_range, clk_i, rst_ni, 1'b1, depth_q <= tlpm_pkg::DEPTH_MAX)
  `TLPM_ASSERT_IMPL(a_child_alloc, clk_i, rst_ni, cmd_i.step && descend,
    UW'(child) < nodes_used_q)
  `TLPM_ASSERT_NEXT(a_alloc_count, clk_i, rst_ni, cmd_i.step && alloc,
    nodes_used_q == $past(nodes_used_q) + UW'(1))

endmodule

FILE: design/trie_longest_prefix_match.sv
`timescale 1ns / 1ps
`include "trie_longest_prefix_match_defines.svh"

// IPv4 route table as a unibit binary trie. A word with tuser 0 inserts a
// route (prefix, netmask, next hop, port); tuser 1 looks up a destination
// and returns the longest stored prefix on its path. One result word per
// input word. Items are handled one at a time: the word is accepted, the
// trie is walked one level per step down to at most 32 levels, a closing
// step ends the walk, the route is stored or the matched route fetched,
// and the result register is loaded once free. The walk is bound by the
// single node store port: one node read or one link write per level. The
// next word is accepted while a result still waits on the master side.
// Nodes are handed out in order from a fill count and cleared when handed
// out; the root is kept in flops, so no clearing pass follows reset.
module trie_longest_prefix_match #(
  parameter int NODES = tlpm_pkg::NODES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // slave side
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // [31:0] key_addr, [63:32] mask, [95:64] hop_addr, [103:96] port
  input  logic [103:0]  s_axis_tdata,
  // [0] func
  input  logic [0:0]    s_axis_tuser,
  // master side
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [31:0] hop_out, [39:32] port_out, [45:40] match_len, [47:46] zero
  output logic [47:0]   m_axis_tdata,
  // [1:0] status
  output logic [1:0]    m_axis_tuser
);

  tlpm_pkg::cmd_t cmd;
  tlpm_pkg::sts_t sts;

  logic [tlpm_pkg::HOP_W-1:0]  hop_out;
  logic [tlpm_pkg::PORT_W-1:0] port_out;
  logic [tlpm_pkg::LEN_W-1:0]  match_len;

  tlpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tlpm_dp #(
    .NODES (NODES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .func_i      (s_axis_tuser[0]),
    .key_addr_i  (s_axis_tdata[31:0]),
    .mask_i      (s_axis_tdata[63:32]),
    .hop_addr_i  (s_axis_tdata[95:64]),
    .port_i      (s_axis_tdata[103:96]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_o    (m_axis_tuser),
    .hop_out_o   (hop_out),
    .port_out_o  (port_out),
    .match_len_o (match_len)
  );

  assign m_axis_tdata = {2'b00, match_len, port_out, hop_out};

endmodule
